// File: rtl/saw_pkg.sv
// Shared types and constants for the stop-and-wait sender.
// Used by saw_front, saw_back and stop_and_wait_arq_sender.
`default_nettype none

package saw_pkg;

  // Kind of input beat
  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_ACK  = 1'b1
  } req_kind_t;

  // Classified item handed from the front queue to the back end
  typedef struct packed {
    req_kind_t   kind;
    logic [15:0] ack_seq;
    logic [7:0]  data;
  } q_item_t;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration register map (index = paddr[3:2])
  localparam int PADDR_BITS = 4;
  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_SOURCE  = 2'd1,
    REG_TARGET  = 2'd2
  } reg_idx_t;

  localparam logic [15:0] TIMEOUT_RESET = 16'd3416;
  localparam logic [7:0]  SOURCE_RESET  = 8'd0;
  localparam logic [7:0]  TARGET_RESET  = 8'd3;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// File: rtl/stop_and_wait_arq_sender.sv
// Stop-and-wait ARQ sender top level: configuration registers on an
// APB-style port, front queue (saw_front) and sender back end (saw_back).
// Depends on saw_pkg, saw_front and saw_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat per tick or arriving ack.
//   in_req_type = 0 is a tick carrying in_offered_data, 1 an ack carrying
//   in_ack_seq. Every input beat yields exactly one result beat on the
//   output channel (out_valid/out_ready): a packet (new or resent) or
//   an accepted-ack report, all fields zero where nothing happened.
//   Throughput: one beat per cycle while out_ready stays high. Each
//   input beat is stored in the two-entry queue, then the back end
//   updates its state and loads the output register with the result.
//   When the receiver stalls, the output register holds its beat, the
//   queue fills and in_ready drops once both entries are taken.
//   Reset (rst_n low, synchronous) empties the queue, frees the sender,
//   clears sequence numbers and the tick counter, and loads the register
//   defaults: timeout 3416, source 0, target 3.
//   Registers: 0x0 timeout_ticks, 0x4 source_id, 0x8 target_id; write
//   them only while no beat is in flight.
`default_nettype none

module stop_and_wait_arq_sender
  import saw_pkg::*;
#(
  parameter int SEQ_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [15:0]           in_ack_seq,
  input  wire logic [7:0]            in_offered_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_send_valid,
  output logic                       out_is_resend,
  output logic [15:0]                out_pkt_seq,
  output logic [7:0]                 out_pkt_data,
  output logic [7:0]                 out_pkt_source,
  output logic [7:0]                 out_pkt_target,
  output logic                       out_ack_accepted,
  output logic [15:0]                out_round_trip_ticks,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [15:0] timeout_ticks_r;
  logic [7:0]  source_id_r;
  logic [7:0]  target_id_r;
  logic        cfg_wr;
  reg_idx_t    reg_idx;
  logic        q_valid;
  logic        q_pop;
  q_item_t     q_item;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[PADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= TIMEOUT_RESET;
      source_id_r     <= SOURCE_RESET;
      target_id_r     <= TARGET_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TIMEOUT: timeout_ticks_r <= pwdata[15:0];
        REG_SOURCE:  source_id_r     <= pwdata[7:0];
        REG_TARGET:  target_id_r     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TIMEOUT: prdata = {16'd0, timeout_ticks_r};
      REG_SOURCE:  prdata = {24'd0, source_id_r};
      REG_TARGET:  prdata = {24'd0, target_id_r};
      default:     prdata = '0;
    endcase
  end

  saw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_ack_seq      (in_ack_seq),
    .in_offered_data (in_offered_data),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  saw_back #(
    .SEQ_BITS (SEQ_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .timeout_ticks        (timeout_ticks_r),
    .source_id            (source_id_r),
    .target_id            (target_id_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_send_valid       (out_send_valid),
    .out_is_resend        (out_is_resend),
    .out_pkt_seq          (out_pkt_seq),
    .out_pkt_data         (out_pkt_data),
    .out_pkt_source       (out_pkt_source),
    .out_pkt_target       (out_pkt_target),
    .out_ack_accepted     (out_ack_accepted),
    .out_round_trip_ticks (out_round_trip_ticks)
  );

endmodule

`default_nettype wire

// File: rtl/saw_front.sv
// Front end: accepts input beats, classifies them as tick or ack and
// queues them for the back end. Depends on saw_pkg.
`default_nettype none

module saw_front
  import saw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [15:0] in_ack_seq,
  input  wire logic [7:0]  in_offered_data,
  output logic             q_valid,
  output q_item_t          q_item,
  input  wire logic        q_pop
);

  q_item_t               entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]  count_r, count_nxt;
  logic                  push;
  logic                  pop;
  q_item_t               new_item;

  assign in_ready = (count_r != QCNT_BITS'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    new_item.kind    = req_kind_t'(in_req_type);
    new_item.ack_seq = in_ack_seq;
    new_item.data    = in_offered_data;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/saw_back.sv
// Back end: sender state (sequence numbers, held packet, tick counter)
// and the registered result beat. Depends on saw_pkg.
`default_nettype none

module saw_back
  import saw_pkg::*;
#(
  parameter int SEQ_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire q_item_t     q_item,
  output logic             q_pop,
  input  wire logic [15:0] timeout_ticks,
  input  wire logic [7:0]  source_id,
  input  wire logic [7:0]  target_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_send_valid,
  output logic             out_is_resend,
  output logic [15:0]      out_pkt_seq,
  output logic [7:0]       out_pkt_data,
  output logic [7:0]       out_pkt_source,
  output logic [7:0]       out_pkt_target,
  output logic             out_ack_accepted,
  output logic [15:0]      out_round_trip_ticks
);

  logic                awaiting_r, awaiting_nxt;
  logic [SEQ_BITS-1:0] next_seq_r, next_seq_nxt;
  logic [SEQ_BITS-1:0] expected_r, expected_nxt;
  logic [SEQ_BITS-1:0] held_seq_r, held_seq_nxt;
  logic [7:0]          held_data_r, held_data_nxt;
  logic [15:0]         ticks_r, ticks_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                send_valid_r, send_valid_nxt;
  logic                is_resend_r, is_resend_nxt;
  logic [15:0]         pkt_seq_r, pkt_seq_nxt;
  logic [7:0]          pkt_data_r, pkt_data_nxt;
  logic [7:0]          pkt_source_r, pkt_source_nxt;
  logic [7:0]          pkt_target_r, pkt_target_nxt;
  logic                ack_acc_r, ack_acc_nxt;
  logic [15:0]         rtt_r, rtt_nxt;

  logic [16:0]         count;
  logic [SEQ_BITS-1:0] ack_m;

  // Take the next item whenever the output register is free or draining
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  assign count = {1'b0, ticks_r} + 17'd1;
  assign ack_m = SEQ_BITS'(q_item.ack_seq);

  always_comb begin
    awaiting_nxt   = awaiting_r;
    next_seq_nxt   = next_seq_r;
    expected_nxt   = expected_r;
    held_seq_nxt   = held_seq_r;
    held_data_nxt  = held_data_r;
    ticks_nxt      = ticks_r;
    send_valid_nxt = 1'b0;
    is_resend_nxt  = 1'b0;
    pkt_seq_nxt    = '0;
    pkt_data_nxt   = '0;
    pkt_source_nxt = '0;
    pkt_target_nxt = '0;
    ack_acc_nxt    = 1'b0;
    rtt_nxt        = '0;
    if (q_pop) begin
      unique case (q_item.kind)
        REQ_TICK: begin
          if (awaiting_r) begin
            if (count > {1'b0, timeout_ticks}) begin
              // timeout: resend held packet and restart the count
              ticks_nxt      = '0;
              send_valid_nxt = 1'b1;
              is_resend_nxt  = 1'b1;
              pkt_seq_nxt    = 16'(held_seq_r);
              pkt_data_nxt   = held_data_r;
              pkt_source_nxt = source_id;
              pkt_target_nxt = target_id;
            end else begin
              ticks_nxt = count[16] ? TICK_MAX : count[15:0];
            end
          end else begin
            held_seq_nxt   = next_seq_r;
            held_data_nxt  = q_item.data;
            next_seq_nxt   = next_seq_r + 1'b1;
            ticks_nxt      = '0;
            awaiting_nxt   = 1'b1;
            send_valid_nxt = 1'b1;
            pkt_seq_nxt    = 16'(next_seq_r);
            pkt_data_nxt   = q_item.data;
            pkt_source_nxt = source_id;
            pkt_target_nxt = target_id;
          end
        end
        REQ_ACK: begin
          // drop acks while free or with the wrong number
          if (awaiting_r && (ack_m == expected_r)) begin
            ack_acc_nxt  = 1'b1;
            rtt_nxt      = ticks_r;
            expected_nxt = expected_r + 1'b1;
            awaiting_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b0;
      next_seq_r  <= '0;
      expected_r  <= '0;
      held_seq_r  <= '0;
      held_data_r <= '0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      awaiting_r  <= awaiting_nxt;
      next_seq_r  <= next_seq_nxt;
      expected_r  <= expected_nxt;
      held_seq_r  <= held_seq_nxt;
      held_data_r <= held_data_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: load on pop, hold while stalled
  always_ff @(posedge clk) begin
    if (q_pop) begin
      send_valid_r <= send_valid_nxt;
      is_resend_r  <= is_resend_nxt;
      pkt_seq_r    <= pkt_seq_nxt;
      pkt_data_r   <= pkt_data_nxt;
      pkt_source_r <= pkt_source_nxt;
      pkt_target_r <= pkt_target_nxt;
      ack_acc_r    <= ack_acc_nxt;
      rtt_r        <= rtt_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_send_valid       = send_valid_r;
  assign out_is_resend        = is_resend_r;
  assign out_pkt_seq          = pkt_seq_r;
  assign out_pkt_data         = pkt_data_r;
  assign out_pkt_source       = pkt_source_r;
  assign out_pkt_target       = pkt_target_r;
  assign out_ack_accepted     = ack_acc_r;
  assign out_round_trip_ticks = rtt_r;

  // While waiting, exactly one packet is outstanding
  a_seq_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> (next_seq_r == expected_r + 1'b1))
    else $error("next sequence not one ahead of expected while waiting");

  a_seq_free: assert property (@(posedge clk) disable iff (!rst_n)
    !awaiting_r |-> (next_seq_r == expected_r))
    else $error("next sequence differs from expected while free");

  a_send_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_item.kind == REQ_TICK) && !awaiting_r) |=> awaiting_r)
    else $error("new send did not enter the waiting state");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(send_valid_r && ack_acc_r))
    else $error("result carries both a packet and an ack");

endmodule

`default_nettype wire
